// ===== design/uniform_histogram_2d_core_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef UNIFORM_HISTOGRAM_2D_CORE_MACROS_SVH
`define UNIFORM_HISTOGRAM_2D_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define UH2D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uh2d assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high
`define UH2D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uh2d assertion failed");

`endif

// ===== design/uh2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uh2d_pkg;

  localparam int MAX_BINS_PER_AXIS = 64;
  localparam int COUNT_WIDTH       = 32;

  localparam int AXIS_BITS = (MAX_BINS_PER_AXIS > 1) ? $clog2(MAX_BINS_PER_AXIS) : 1;
  localparam int BIN_W     = AXIS_BITS + 1;
  localparam int DEPTH     = MAX_BINS_PER_AXIS * MAX_BINS_PER_AXIS;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // One quotient bit per step, plus a top bit that flags "beyond the last bin"
  localparam int DIV_STEPS = AXIS_BITS + 1;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam logic [CFG_INDEX_W-1:0] REG_AXIS1_MIN      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS1_INTERVAL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS1_BINS     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS2_MIN      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS2_INTERVAL = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS2_BINS     = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture a new transaction
    logic div_step;   // advance both dividers one bit
    logic idx_latch;  // latch the clamped bin indexes
    logic rmw;        // capture read data, write back the increment on add
    logic clr_step;   // zero one entry and advance the clear pointer
    logic out_load;   // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic out_free;
  } status_t;

  // Map a configured bin count onto the usable range
  function automatic logic [BIN_W-1:0] bins_used(input logic [6:0] b);
    if (b == 7'd0) begin
      return BIN_W'(1);
    end
    if (int'(b) > MAX_BINS_PER_AXIS) begin
      return BIN_W'(MAX_BINS_PER_AXIS);
    end
    return BIN_W'(b);
  endfunction

  function automatic logic [ADDR_BITS-1:0] bin_addr(input logic [AXIS_BITS-1:0] row,
                                                    input logic [AXIS_BITS-1:0] col);
    return ADDR_BITS'(int'(row) * MAX_BINS_PER_AXIS + int'(col));
  endfunction

  // Saturate a stored count onto the 32 bit result field
  function automatic logic [31:0] count_out(input logic [COUNT_WIDTH-1:0] c);
    if (COUNT_WIDTH > 32 && (c >> 32) != '0) begin
      return 32'hFFFF_FFFF;
    end
    return 32'(c);
  endfunction

endpackage

`default_nettype wire

// ===== design/uniform_histogram_2d_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Handshake             Payload
// in       in_valid / in_ready   op, first_value, second_value, read_row, read_col
// out      out_valid / out_ready count_value, row_index, col_index
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// Add: the result is set by the two 7-step bit-serial
//   dividers plus the read-modify-write of the count memory.
// Read: the memory read, then the output load. Unused op: straight to the output load.
// Clear: one memory entry zeroed per cycle, across all 4096 entries.
// After reset a clearing pass over all 4096 entries runs with in_ready low.
// A finished result waits in the output register; the next transaction may start meanwhile.

module uniform_histogram_2d_core
  import uh2d_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             op,
  input  wire logic signed [31:0]     first_value,
  input  wire logic signed [31:0]     second_value,
  input  wire logic [5:0]             read_row,
  input  wire logic [5:0]             read_col,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [31:0]                 count_value,
  output logic [5:0]                  row_index,
  output logic [5:0]                  col_index,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  uh2d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  uh2d_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .first_value  (first_value),
    .second_value (second_value),
    .read_row     (read_row),
    .read_col     (read_col),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .count_value  (count_value),
    .row_index    (row_index),
    .col_index    (col_index)
  );

endmodule

`default_nettype wire

// ===== design/uh2d_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uh2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/uh2d_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uh2d_ctrl
  import uh2d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] op,
  output logic            in_ready,
  input  wire status_t    status,
  output cmd_t            cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVIDE,
    S_INDEX,
    S_READ,
    S_MODIFY,
    S_FINISH
  } state_t;

  localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic              clr_pending;

  // Sequence one transaction at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      step        <= '0;
      clr_pending <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (status.clr_last) begin
            state       <= clr_pending ? S_FINISH : S_IDLE;
            clr_pending <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            unique case (op)
              OP_ADD: begin
                state <= S_DIVIDE;
                step  <= '0;
              end
              OP_READ: begin
                state <= S_READ;
              end
              OP_CLEAR: begin
                state       <= S_CLEAR;
                clr_pending <= 1'b1;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_DIVIDE: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            state <= S_INDEX;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_INDEX:  state <= S_READ;
        S_READ:   state <= S_MODIFY;
        S_MODIFY: state <= S_FINISH;
        S_FINISH: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Decode commands from the current state
  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.div_step  = (state == S_DIVIDE);
    cmd.idx_latch = (state == S_INDEX);
    cmd.rmw       = (state == S_MODIFY);
    cmd.clr_step  = (state == S_CLEAR);
    cmd.out_load  = (state == S_FINISH) && status.out_free;
  end

endmodule

`default_nettype wire

// ===== design/uh2d_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uh2d_datapath
  import uh2d_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  output status_t                     status,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic [1:0]             op,
  input  wire logic signed [31:0]     first_value,
  input  wire logic signed [31:0]     second_value,
  input  wire logic [5:0]             read_row,
  input  wire logic [5:0]             read_col,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [31:0]                 count_value,
  output logic [5:0]                  row_index,
  output logic [5:0]                  col_index
);

  localparam int DSH_W = 31 + AXIS_BITS;

  logic signed [31:0] axis_min [2];
  logic [30:0]        axis_int [2];
  logic [6:0]         axis_bins [2];

  logic [1:0]           op_r;
  logic [31:0]          rem [2];
  logic [DSH_W-1:0]     dsh [2];
  logic [DIV_STEPS-1:0] quo [2];
  logic                 neg [2];
  logic [AXIS_BITS-1:0] idx [2];
  logic [AXIS_BITS-1:0] row, col;

  logic [ADDR_BITS-1:0]   clr_ptr;
  logic                   clr_last;
  logic [COUNT_WIDTH-1:0] rdata, inc_count, res_count;
  logic                   ram_we;
  logic [ADDR_BITS-1:0]   ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;

  // Hold the axis configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_min[0]  <= '0;
      axis_int[0]  <= 31'd65536;
      axis_bins[0] <= 7'd64;
      axis_min[1]  <= '0;
      axis_int[1]  <= 31'd65536;
      axis_bins[1] <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AXIS1_MIN:      axis_min[0]  <= cfg_data;
        REG_AXIS1_INTERVAL: axis_int[0]  <= cfg_data[30:0];
        REG_AXIS1_BINS:     axis_bins[0] <= cfg_data[6:0];
        REG_AXIS2_MIN:      axis_min[1]  <= cfg_data;
        REG_AXIS2_INTERVAL: axis_int[1]  <= cfg_data[30:0];
        REG_AXIS2_BINS:     axis_bins[1] <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Clamp each quotient onto the configured bins
  always_comb begin
    logic [BIN_W-1:0]     n;
    logic [AXIS_BITS-1:0] last;
    for (int a = 0; a < 2; a++) begin
      n    = bins_used(axis_bins[a]);
      last = AXIS_BITS'(n - BIN_W'(1));
      if (neg[a]) begin
        idx[a] = '0;
      end else if (quo[a][AXIS_BITS] || BIN_W'(quo[a][AXIS_BITS-1:0]) >= n) begin
        idx[a] = last;
      end else begin
        idx[a] = quo[a][AXIS_BITS-1:0];
      end
    end
  end

  // Capture the transaction, then run both restoring dividers in step
  always_ff @(posedge clk) begin
    logic signed [32:0] diff;
    logic [30:0]        d;
    if (cmd.load) begin
      op_r <= op;
      for (int a = 0; a < 2; a++) begin
        diff   = (a == 0) ? (33'(first_value) - 33'(axis_min[a]))
                          : (33'(second_value) - 33'(axis_min[a]));
        d      = (axis_int[a] == '0) ? 31'd1 : axis_int[a];
        neg[a] <= diff[32];
        rem[a] <= diff[31:0];
        dsh[a] <= {d, AXIS_BITS'(0)};
        quo[a] <= '0;
      end
      if (op == OP_READ) begin
        row <= (int'(read_row) >= MAX_BINS_PER_AXIS) ? AXIS_BITS'(MAX_BINS_PER_AXIS - 1)
                                                     : AXIS_BITS'(read_row);
        col <= (int'(read_col) >= MAX_BINS_PER_AXIS) ? AXIS_BITS'(MAX_BINS_PER_AXIS - 1)
                                                     : AXIS_BITS'(read_col);
      end else begin
        row <= '0;
        col <= '0;
      end
    end else if (cmd.div_step) begin
      for (int a = 0; a < 2; a++) begin
        if (DSH_W'(rem[a]) >= dsh[a]) begin
          rem[a] <= rem[a] - dsh[a][31:0];
          quo[a] <= {quo[a][DIV_STEPS-2:0], 1'b1};
        end else begin
          quo[a] <= {quo[a][DIV_STEPS-2:0], 1'b0};
        end
        dsh[a] <= dsh[a] >> 1;
      end
    end else if (cmd.idx_latch) begin
      row <= idx[0];
      col <= idx[1];
    end
  end

  // Advance the clear pointer, one entry a cycle
  assign clr_last = (clr_ptr == ADDR_BITS'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.clr_step) begin
      clr_ptr <= clr_last ? '0 : clr_ptr + ADDR_BITS'(1);
    end
  end

  // Count memory: zero writes during a clear, increments on add
  assign inc_count = (rdata == '1) ? rdata : rdata + COUNT_WIDTH'(1);
  assign ram_we    = cmd.clr_step || (cmd.rmw && op_r == OP_ADD);
  assign ram_waddr = cmd.clr_step ? clr_ptr : bin_addr(row, col);
  assign ram_wdata = cmd.clr_step ? '0 : inc_count;

  uh2d_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (bin_addr(row, col)),
    .rdata (rdata)
  );

  // Form the result count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_count <= '0;
    end else if (cmd.rmw) begin
      res_count <= (op_r == OP_ADD) ? inc_count : rdata;
    end
  end

  // Output register: hold until the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      count_value <= count_out(res_count);
      row_index   <= 6'(row);
      col_index   <= 6'(col);
    end
  end

  assign status.clr_last = clr_last;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== design/uh2d_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "uniform_histogram_2d_core_macros.svh"

module uh2d_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] count_value,
  input wire logic [5:0]  row_index,
  input wire logic [5:0]  col_index
);

  // The clearing pass follows reset before any transaction is taken
  `UH2D_ASSERT_NOW(a_clear_after_reset, $past(rst), !in_ready)

  // One transaction at a time: ready drops right after an accept
  `UH2D_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // A stalled result holds with its payload
  `UH2D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(count_value) && $stable(row_index) && $stable(col_index))

endmodule

bind uniform_histogram_2d_core uh2d_checker u_chk (.*);

`default_nettype wire

// ===== verif/uniform_histogram_2d_core_test.sv =====
`timescale 1ns / 1ps

module uniform_histogram_2d_core_test;
  import uh2d_pkg::*;

  localparam logic [1:0]             OP_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [31:0] count;
    logic [5:0]  row;
    logic [5:0]  col;
  } bin_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             op = 2'd0;
  logic signed [31:0]     first_value = '0;
  logic signed [31:0]     second_value = '0;
  logic [5:0]             read_row = '0;
  logic [5:0]             read_col = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [31:0]            count_value;
  logic [5:0]             row_index;
  logic [5:0]             col_index;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  // Shadow histogram and axis settings
  logic [31:0]        tally [DEPTH];
  logic signed [31:0] ax_min [2];
  logic [30:0]        ax_interval [2];
  logic [6:0]         ax_bins [2];
  logic [5:0]         last_row;
  logic [5:0]         last_col;

  bin_result_t expected_bins [$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          in_held = 1'b0;

  uniform_histogram_2d_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .first_value(first_value),
    .second_value(second_value),
    .read_row(read_row),
    .read_col(read_col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .count_value(count_value),
    .row_index(row_index),
    .col_index(col_index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int eff_bins(input logic [6:0] nbins);
    if (nbins == 7'd0) return 1;
    if (int'(nbins) > MAX_BINS_PER_AXIS) return MAX_BINS_PER_AXIS;
    return int'(nbins);
  endfunction

  // Uniform bin lookup; below the minimum is bin 0, beyond the range the last bin
  function automatic logic [5:0] axis_bin(input logic signed [31:0] sample,
                                          input logic signed [31:0] lo,
                                          input logic [30:0] width,
                                          input logic [6:0] nbins);
    longint diff;
    longint span;
    longint q;
    diff = longint'(sample) - longint'(lo);
    span = (width == 31'd0) ? 64'sd1 : longint'(width);
    if (diff < 0) return 6'd0;
    q = diff / span;
    if (q >= longint'(eff_bins(nbins))) q = longint'(eff_bins(nbins) - 1);
    return q[5:0];
  endfunction

  // Apply one transaction to the shadow histogram and queue its result
  function automatic void predict_bin_access(input logic [1:0] code,
                                             input logic signed [31:0] fv,
                                             input logic signed [31:0] sv,
                                             input logic [5:0] rr,
                                             input logic [5:0] rc);
    bin_result_t res;
    int          addr;
    res = '0;
    case (code)
      OP_ADD: begin
        res.row = axis_bin(fv, ax_min[0], ax_interval[0], ax_bins[0]);
        res.col = axis_bin(sv, ax_min[1], ax_interval[1], ax_bins[1]);
        addr = int'(res.row) * MAX_BINS_PER_AXIS + int'(res.col);
        if (tally[addr] != 32'hFFFF_FFFF) tally[addr] = tally[addr] + 32'd1;
        res.count = tally[addr];
        last_row = res.row;
        last_col = res.col;
      end
      OP_READ: begin
        res.row = (int'(rr) >= MAX_BINS_PER_AXIS) ? 6'(MAX_BINS_PER_AXIS - 1) : rr;
        res.col = (int'(rc) >= MAX_BINS_PER_AXIS) ? 6'(MAX_BINS_PER_AXIS - 1) : rc;
        res.count = tally[int'(res.row) * MAX_BINS_PER_AXIS + int'(res.col)];
      end
      OP_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) tally[i] = '0;
      end
      default: ;
    endcase
    expected_bins.push_back(res);
  endfunction

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    bin_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: result with nothing pending: count %0d row %0d col %0d",
                 $time, count_value, row_index, col_index);
        errors++;
      end else begin
        want = expected_bins.pop_front();
        if (count_value !== want.count) begin
          $display("%0t: count_value mismatch: expected %0d, got %0d",
                   $time, want.count, count_value);
          errors++;
        end
        if (row_index !== want.row) begin
          $display("%0t: row_index mismatch: expected %0d, got %0d",
                   $time, want.row, row_index);
          errors++;
        end
        if (col_index !== want.col) begin
          $display("%0t: col_index mismatch: expected %0d, got %0d",
                   $time, want.col, col_index);
          errors++;
        end
      end
    end
  end

  // Offer one transaction after a random idle gap, hold it until accepted
  task automatic send_item(input logic [1:0] code, input logic [31:0] fv,
                           input logic [31:0] sv, input logic [5:0] rr,
                           input logic [5:0] rc);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      if (in_held) in_valid <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_held      = 1'b1;
    op           <= code;
    first_value  <= fv;
    second_value <= sv;
    read_row     <= rr;
    read_col     <= rc;
    do @(posedge clk); while (!in_ready);
    predict_bin_access(code, fv, sv, rr, rc);
  endtask

  // Drop the input channel and hold until every result is back
  task automatic wait_for_results();
    if (in_held) in_valid <= 1'b0;
    in_held = 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_AXIS1_MIN:      ax_min[0] = data;
      REG_AXIS1_INTERVAL: ax_interval[0] = data[30:0];
      REG_AXIS1_BINS:     ax_bins[0] = data[6:0];
      REG_AXIS2_MIN:      ax_min[1] = data;
      REG_AXIS2_INTERVAL: ax_interval[1] = data[30:0];
      REG_AXIS2_BINS:     ax_bins[1] = data[6:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] min1, input logic [31:0] int1,
                           input logic [31:0] bins1, input logic [31:0] min2,
                           input logic [31:0] int2, input logic [31:0] bins2);
    write_reg(REG_AXIS1_MIN, min1);
    write_reg(REG_AXIS1_INTERVAL, int1);
    write_reg(REG_AXIS1_BINS, bins1);
    write_reg(REG_AXIS2_MIN, min2);
    write_reg(REG_AXIS2_INTERVAL, int2);
    write_reg(REG_AXIS2_BINS, bins2);
    cfg_valid <= 1'b0;
  endtask

  // Sample near the axis range: mostly inside, some below, some past the end
  function automatic logic [31:0] pick_sample(input int axis);
    longint span;
    longint k;
    longint v;
    span = (ax_interval[axis] == 31'd0) ? 64'sd1 : longint'(ax_interval[axis]);
    case ($urandom_range(19))
      0, 1, 2: v = longint'($urandom);
      3:       v = longint'(ax_min[axis]) - longint'($urandom_range(5000, 1));
      default: begin
        k = longint'($urandom_range(eff_bins(ax_bins[axis]) + 1, 0));
        v = longint'(ax_min[axis]) + k * span
            + longint'($urandom_range(32'(span - 1), 0));
      end
    endcase
    return v[31:0];
  endfunction

  // Default axes: edges of the sample range, negative offsets, read, unused op, clear
  task automatic test_reset_defaults();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(OP_READ, '0, '0, 6'd0, 6'd0);
    send_item(OP_ADD, 32'd0, 32'd0, '0, '0);
    send_item(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
    send_item(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0);
    send_item(OP_ADD, 32'h0005_FFFF, 32'h0003_0000, '0, '0);
    send_item(OP_ADD, 32'd0, 32'd0, 6'h3F, 6'h3F);
    send_item(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 6'd0);
    send_item(OP_READ, '0, '0, 6'd63, 6'd63);
    send_item(OP_READ, '0, '0, 6'd5, 6'd3);
    send_item(OP_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0, 6'd17, 6'd42);
    send_item(OP_CLEAR, '0, '0, 6'd9, 6'd9);
    send_item(OP_READ, '0, '0, 6'd0, 6'd0);
    wait_for_results();
  endtask

  // Zero interval and zero bin count, oversize bin count, extreme minimums
  task automatic test_config_extremes();
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    configure(32'h8000_0000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd127);
    send_item(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0);
    send_item(OP_ADD, 32'h8000_0000, 32'h8000_0000, '0, '0);
    send_item(OP_READ, '0, '0, 6'd0, 6'd0);
    wait_for_results();
    configure(32'd0, 32'd1, 32'd64, 32'h8000_0000, 32'h8000_0001, 32'd65);
    send_item(OP_ADD, 32'd63, 32'h8000_003E, '0, '0);
    send_item(OP_ADD, 32'd64, 32'd0, '0, '0);
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0, '0);
    send_item(OP_READ, '0, '0, 6'd63, 6'd62);
    send_item(OP_READ, '0, '0, 6'd0, 6'd63);
    wait_for_results();
  endtask

  // Random axes, then a stream of mostly adds with reads of recent bins
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct, input bit pause_midway);
    logic [31:0] mins [2];
    logic [31:0] spans [2];
    logic [31:0] counts [2];
    int          pick;
    logic [5:0]  rr;
    logic [5:0]  rc;
    for (int a = 0; a < 2; a++) begin
      case ($urandom_range(3))
        0:       mins[a] = '0;
        1:       mins[a] = $urandom;
        default: mins[a] = 32'($urandom_range(200000) - 100000);
      endcase
      case ($urandom_range(3))
        0:       spans[a] = $urandom_range(32'h7FFF_FFFF, 0);
        1:       spans[a] = 32'd65536;
        default: spans[a] = $urandom_range(1 << 18, 1);
      endcase
      case ($urandom_range(3))
        0:       counts[a] = $urandom_range(127, 0);
        1:       counts[a] = $urandom_range(4, 1);
        default: counts[a] = $urandom_range(64, 1);
      endcase
    end
    configure(mins[0], spans[0], counts[0], mins[1], spans[1], counts[1]);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (pause_midway && i == n_items / 2) wait_for_results();
      pick = $urandom_range(99);
      rr = 6'($urandom);
      rc = 6'($urandom);
      if (pick < 72) begin
        send_item(OP_ADD, pick_sample(0), pick_sample(1), rr, rc);
      end else if (pick < 95) begin
        if ($urandom_range(1) == 0) begin
          rr = last_row;
          rc = last_col;
        end
        send_item(OP_READ, $urandom, $urandom, rr, rc);
      end else if (pick < 99) begin
        send_item(OP_UNUSED, $urandom, $urandom, rr, rc);
      end else begin
        send_item(OP_CLEAR, $urandom, $urandom, rr, rc);
      end
    end
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) tally[i] = '0;
    ax_min[0]      = '0;
    ax_min[1]      = '0;
    ax_interval[0] = 31'd65536;
    ax_interval[1] = 31'd65536;
    ax_bins[0]     = 7'd64;
    ax_bins[1]     = 7'd64;
    last_row       = '0;
    last_col       = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_config_extremes();
    test_random_traffic(195, 0, 0, 1'b0);
    test_random_traffic(195, 0, 0, 1'b0);
    test_random_traffic(195, 76, 0, 1'b0);
    test_random_traffic(195, 76, 0, 1'b1);
    test_random_traffic(195, 0, 76, 1'b0);
    test_random_traffic(195, 0, 76, 1'b0);
    test_random_traffic(195, 26, 26, 1'b0);
    test_random_traffic(195, 26, 26, 1'b0);

    wait_for_results();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/uh2d_pkg.sv
design/uh2d_ram.sv
design/uh2d_ctrl.sv
design/uh2d_datapath.sv
design/uniform_histogram_2d_core.sv
design/uh2d_checker.sv
verif/uniform_histogram_2d_core_test.sv
